// ----- hw/rtl/dtfb_pkg.sv -----
// Package for the depth-tested fill and blend engine.
// Holds the opcode and register codes, geometry widths and the blend function.
// No dependencies.
package dtfb_pkg;

    // Default framebuffer limits
    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    // Field widths
    localparam int GW         = 14;  // signed geometry math
    localparam int DIM_W      = 11;  // frame dimension up to 1024
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int PIX_W      = 40;  // {layer, argb}

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_RECT  = 2'd1,
        OP_TRI   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic [1:0] DIR_DOWN = 2'd0;
    localparam logic [1:0] DIR_UP   = 2'd1;
    localparam logic [1:0] DIR_LEFT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_LEFT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_TOP     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_SPAN_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIP_SPAN_Y  = 3'd5;

    localparam logic [8:0]  FRAME_DIM_RST = 9'd256;
    localparam logic [11:0] CLIP_SPAN_RST = 12'd257;
    localparam logic [31:0] CLEAR_COLOR   = 32'hFFFF_FFFF;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic setup;
        logic prep;
        logic walk;
        logic clear;
        logic rd_issue;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t  op;
        logic empty;
        logic walk_last;
        logic clear_none;
        logic clear_last;
        logic out_free;
    } status_t;

    // (s*a + d*(255-a)) / 255, truncated; exact for 16-bit sums
    function automatic logic [7:0] mix(input logic [7:0] s, input logic [7:0] d,
                                       input logic [7:0] a);
        logic [15:0] v;
        logic [16:0] t;
        v = 16'(s * a) + 16'(d * (8'd255 - a));
        t = 17'(v) + 17'd1 + 17'(v[15:8]);
        return t[15:8];
    endfunction

endpackage

// ----- hw/rtl/dtfb_item_if.sv -----
// Input command channel of the fill and blend engine.
// Depends on nothing.
interface dtfb_item_if;
    logic              valid;
    logic              ready;
    logic [1:0]        opcode;
    logic signed [10:0] pos_x;
    logic signed [10:0] pos_y;
    logic [9:0]        span_w;
    logic [9:0]        span_h;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    logic [7:0]        opacity;
    logic [7:0]        layer;
    logic [1:0]        direction;

    modport source (output valid, opcode, pos_x, pos_y, span_w, span_h, red, green, blue,
                    opacity, layer, direction, input ready);
    modport sink (input valid, opcode, pos_x, pos_y, span_w, span_h, red, green, blue,
                  opacity, layer, direction, output ready);
endinterface

// ----- hw/rtl/dtfb_result_if.sv -----
// Result channel of the fill and blend engine.
// Depends on nothing.
interface dtfb_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_color;
    logic [7:0]  pixel_layer;

    modport source (output valid, pixel_color, pixel_layer, input ready);
    modport sink (input valid, pixel_color, pixel_layer, output ready);
endinterface

// ----- hw/rtl/dtfb_cfg_if.sv -----
// Register write channel of the fill and blend engine.
// Depends on nothing.
interface dtfb_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [11:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/dtfb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module dtfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end
endmodule

// ----- hw/rtl/dtfb_datapath.sv -----
// Datapath: registers, clipping, pixel walk, blend and the pixel memory.
// Depends on dtfb_pkg and dtfb_ram.
module dtfb_datapath #(
    parameter int MAX_WIDTH  = dtfb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtfb_pkg::MAX_HEIGHT_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dtfb_pkg::cmd_t                      cmd,
    output dtfb_pkg::status_t                   status,
    input  logic                                cfg_we,
    input  logic [dtfb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dtfb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic [1:0]                          opcode,
    input  logic signed [10:0]                  pos_x,
    input  logic signed [10:0]                  pos_y,
    input  logic [9:0]                          span_w,
    input  logic [9:0]                          span_h,
    input  logic [7:0]                          red,
    input  logic [7:0]                          green,
    input  logic [7:0]                          blue,
    input  logic [7:0]                          opacity,
    input  logic [7:0]                          layer,
    input  logic [1:0]                          direction,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [31:0]                         pixel_color,
    output logic [7:0]                          pixel_layer
);
    localparam int GW    = dtfb_pkg::GW;
    localparam int DW    = dtfb_pkg::DIM_W;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(DEPTH + 1);

    // Configuration registers
    logic [8:0]         fwidth_reg, fheight_reg;
    logic signed [10:0] clip_left_reg, clip_top_reg;
    logic [11:0]        span_x_reg, span_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwidth_reg    <= dtfb_pkg::FRAME_DIM_RST;
            fheight_reg   <= dtfb_pkg::FRAME_DIM_RST;
            clip_left_reg <= '0;
            clip_top_reg  <= '0;
            span_x_reg    <= dtfb_pkg::CLIP_SPAN_RST;
            span_y_reg    <= dtfb_pkg::CLIP_SPAN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                dtfb_pkg::CFG_FRAME_WIDTH:  fwidth_reg    <= cfg_data[8:0];
                dtfb_pkg::CFG_FRAME_HEIGHT: fheight_reg   <= cfg_data[8:0];
                dtfb_pkg::CFG_CLIP_LEFT:    clip_left_reg <= cfg_data[10:0];
                dtfb_pkg::CFG_CLIP_TOP:     clip_top_reg  <= cfg_data[10:0];
                dtfb_pkg::CFG_CLIP_SPAN_X:  span_x_reg    <= cfg_data;
                dtfb_pkg::CFG_CLIP_SPAN_Y:  span_y_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame size in use, saturated to the memory limits
    logic [DW-1:0] fw, fh;
    assign fw = (DW'(fwidth_reg) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(fwidth_reg);
    assign fh = (DW'(fheight_reg) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(fheight_reg);

    // Latched command word
    dtfb_pkg::op_t      op_reg;
    logic signed [10:0] px_reg, py_reg;
    logic [9:0]         w_reg, h_reg;
    logic [7:0]         r_reg, g_reg, b_reg, a_reg, lay_reg;
    logic [1:0]         dir_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= dtfb_pkg::op_t'(opcode);
            px_reg  <= pos_x;
            py_reg  <= pos_y;
            w_reg   <= span_w;
            h_reg   <= span_h;
            r_reg   <= red;
            g_reg   <= green;
            b_reg   <= blue;
            a_reg   <= opacity;
            lay_reg <= layer;
            dir_reg <= direction;
        end
    end

    // Clipping: clamp at zero, then scissor, then frame bounds
    logic signed [GW-1:0] px_s, py_s, w_s, h_s, fw_s, fh_s;
    logic signed [GW-1:0] cl_s, ct_s, csx_s, csy_s, clip_r, clip_b;
    logic signed [GW-1:0] sx0, sy0, ex0, ey0, sx1, sy1, ex1, ey1;
    assign px_s  = GW'(px_reg);
    assign py_s  = GW'(py_reg);
    assign w_s   = GW'(w_reg);
    assign h_s   = GW'(h_reg);
    assign fw_s  = GW'(fw);
    assign fh_s  = GW'(fh);
    assign cl_s  = GW'(clip_left_reg);
    assign ct_s  = GW'(clip_top_reg);
    assign csx_s = GW'(span_x_reg);
    assign csy_s = GW'(span_y_reg);

    always_comb
    begin
        clip_r = cl_s + csx_s;
        clip_b = ct_s + csy_s;
        sx0 = (px_s < 0) ? '0 : px_s;
        sy0 = (py_s < 0) ? '0 : py_s;
        ex0 = sx0 + w_s;
        ey0 = sy0 + h_s;
        sx1 = (sx0 < cl_s) ? cl_s : sx0;
        sy1 = (sy0 < ct_s) ? ct_s : sy0;
        ex1 = (ex0 > clip_r) ? clip_r : ex0;
        ey1 = (ey0 > clip_b) ? clip_b : ey0;
        if (ex1 > fw_s)
        begin
            ex1 = fw_s;
        end
        if (ey1 > fh_s)
        begin
            ey1 = fh_s;
        end
    end

    // Read address and bounds, clear count
    logic              rd_inb;
    logic [2*DW-1:0]   rd_prod, n_prod;
    assign rd_inb  = (px_s >= 0) && (py_s >= 0) && (px_s < fw_s) && (py_s < fh_s);
    assign rd_prod = DW'(py_reg[9:0]) * fw + (2*DW)'(px_reg[9:0]);
    assign n_prod  = fw * fh;

    logic signed [GW-1:0] sx_reg, sy_reg, ex_reg, ey_reg;
    logic signed [GW-1:0] acw_reg, ach_reg, x_reg, y_reg;
    logic                 inb_reg;
    logic [AW-1:0]        rd_addr_reg, row_base_reg;
    logic [NW-1:0]        n_reg, cnt_reg;
    logic [2*DW-1:0]      base_prod;
    assign base_prod = DW'(sy_reg) * fw;

    logic x_end;
    assign x_end = (x_reg == ex_reg - GW'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.setup)
        begin
            sx_reg      <= sx1;
            sy_reg      <= sy1;
            ex_reg      <= ex1;
            ey_reg      <= ey1;
            inb_reg     <= rd_inb;
            rd_addr_reg <= rd_prod[AW-1:0];
            n_reg       <= n_prod[NW-1:0];
        end
        if (cmd.prep)
        begin
            row_base_reg <= base_prod[AW-1:0];
            x_reg        <= sx_reg;
            y_reg        <= sy_reg;
            acw_reg      <= ex_reg - sx_reg;
            ach_reg      <= ey_reg - sy_reg;
            cnt_reg      <= '0;
        end
        else if (cmd.walk)
        begin
            if (x_end)
            begin
                x_reg        <= sx_reg;
                y_reg        <= y_reg + GW'(1);
                row_base_reg <= row_base_reg + AW'(fw);
            end
            else
            begin
                x_reg <= x_reg + GW'(1);
            end
        end
        else if (cmd.clear)
        begin
            cnt_reg <= cnt_reg + NW'(1);
        end
    end

    // Triangle coverage of the current pixel
    logic signed [GW-1:0] lx, ly, hy, ry, hry, rx, hrx;
    logic                 cov;
    always_comb
    begin
        lx  = x_reg - sx_reg;
        ly  = y_reg - sy_reg;
        hy  = ly >>> 1;
        ry  = ach_reg - ly;
        hry = ry >>> 1;
        rx  = acw_reg - lx;
        hrx = rx >>> 1;
        cov = 1'b1;
        if (op_reg == dtfb_pkg::OP_TRI)
        begin
            unique case (dir_reg)
                dtfb_pkg::DIR_DOWN: cov = !(lx < hy || lx >= acw_reg - hy - GW'(1));
                dtfb_pkg::DIR_UP:   cov = !(lx < hry || lx >= acw_reg - hry);
                dtfb_pkg::DIR_LEFT: cov = !(hrx > ry - GW'(1) || hrx >= acw_reg - ry);
                default:            cov = 1'b0;
            endcase
        end
    end

    // Pixel pipeline: read now, blend and write back next cycle
    logic                p_valid_reg, p_cov_reg;
    logic [AW-1:0]       p_addr_reg, walk_addr;
    assign walk_addr = row_base_reg + AW'(x_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= cmd.walk;
        end
    end

    always_ff @(posedge clk)
    begin
        p_cov_reg  <= cov;
        p_addr_reg <= walk_addr;
    end

    logic                         we, re;
    logic [AW-1:0]                waddr, raddr;
    logic [dtfb_pkg::PIX_W-1:0]   wdata, rdata;

    always_comb
    begin
        we    = 1'b0;
        waddr = p_addr_reg;
        wdata = {lay_reg, a_reg,
                 dtfb_pkg::mix(r_reg, rdata[23:16], a_reg),
                 dtfb_pkg::mix(g_reg, rdata[15:8], a_reg),
                 dtfb_pkg::mix(b_reg, rdata[7:0], a_reg)};
        priority if (cmd.clear)
        begin
            we    = 1'b1;
            waddr = cnt_reg[AW-1:0];
            wdata = {8'h00, dtfb_pkg::CLEAR_COLOR};
        end
        else if (p_valid_reg && p_cov_reg && (rdata[39:32] <= lay_reg))
        begin
            we = 1'b1;
        end
    end

    assign re    = cmd.walk | cmd.rd_issue;
    assign raddr = cmd.walk ? walk_addr : rd_addr_reg;

    dtfb_ram #(
        .WIDTH (dtfb_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_pix_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Output word register
    logic        out_valid_reg;
    logic [31:0] color_reg;
    logic [7:0]  olay_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (op_reg == dtfb_pkg::OP_READ && inb_reg)
            begin
                color_reg <= rdata[31:0];
                olay_reg  <= rdata[39:32];
            end
            else
            begin
                color_reg <= '0;
                olay_reg  <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_color = color_reg;
    assign pixel_layer = olay_reg;

    // Status back to the controller
    assign status.op         = op_reg;
    assign status.empty      = (sx_reg >= ex_reg) || (sy_reg >= ey_reg);
    assign status.walk_last  = x_end && (y_reg == ey_reg - GW'(1));
    assign status.clear_none = (n_reg == '0);
    assign status.clear_last = (cnt_reg == n_reg - NW'(1));
    assign status.out_free   = !out_valid_reg || out_ready;
endmodule

// ----- hw/rtl/dtfb_ctrl.sv -----
// Controller: sequences setup, pixel walk, clear sweep, read and result.
// Depends on dtfb_pkg.
module dtfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dtfb_pkg::status_t status,
    output dtfb_pkg::cmd_t    cmd
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_PREP,
        S_WALK,
        S_CLEAR,
        S_RDISSUE,
        S_RESP
    } state_t;

    state_t state_reg, state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:    if (in_valid) state_next = S_SETUP;
            S_SETUP:   state_next = S_PREP;
            S_PREP:
            begin
                unique case (status.op)
                    dtfb_pkg::OP_CLEAR: state_next = status.clear_none ? S_RESP : S_CLEAR;
                    dtfb_pkg::OP_READ:  state_next = S_RDISSUE;
                    default:            state_next = status.empty ? S_RESP : S_WALK;
                endcase
            end
            S_WALK:    if (status.walk_last) state_next = S_RESP;
            S_CLEAR:   if (status.clear_last) state_next = S_RESP;
            S_RDISSUE: state_next = S_RESP;
            S_RESP:    if (status.out_free) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Command decode
    assign in_ready     = (state_reg == S_IDLE);
    assign cmd.load     = in_ready && in_valid;
    assign cmd.setup    = (state_reg == S_SETUP);
    assign cmd.prep     = (state_reg == S_PREP);
    assign cmd.walk     = (state_reg == S_WALK);
    assign cmd.clear    = (state_reg == S_CLEAR);
    assign cmd.rd_issue = (state_reg == S_RDISSUE);
    assign cmd.out_load = (state_reg == S_RESP) && status.out_free;
endmodule

// ----- hw/rtl/depth_tested_fill_blend_engine_unit.sv -----
// Depth-tested fill and blend engine: a framebuffer of ARGB color and 8-bit
// depth with clear, rectangle fill, triangle fill and pixel read commands,
// one result word per command. Commands run one at a time. A fill walks the
// clipped bounding box one pixel per cycle through the single read port and
// single write port of the pixel memory; a clear sweeps the width*height
// pixels of the frame in use, one pixel written per cycle.
// Register writes are taken at any time and must only be made while idle.
// Depends on dtfb_pkg, the channel interfaces, dtfb_ctrl and dtfb_datapath.
module depth_tested_fill_blend_engine_unit #(
    parameter int MAX_WIDTH  = dtfb_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = dtfb_pkg::MAX_HEIGHT_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    dtfb_item_if.sink       item,
    dtfb_result_if.source   result,
    dtfb_cfg_if.sink        cfg
);
    dtfb_pkg::cmd_t    cmd;
    dtfb_pkg::status_t status;

    // Registers are always writable
    assign cfg.ready = 1'b1;

    dtfb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    dtfb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.index),
        .cfg_data    (cfg.data),
        .opcode      (item.opcode),
        .pos_x       (item.pos_x),
        .pos_y       (item.pos_y),
        .span_w      (item.span_w),
        .span_h      (item.span_h),
        .red         (item.red),
        .green       (item.green),
        .blue        (item.blue),
        .opacity     (item.opacity),
        .layer       (item.layer),
        .direction   (item.direction),
        .out_valid   (result.valid),
        .out_ready   (result.ready),
        .pixel_color (result.pixel_color),
        .pixel_layer (result.pixel_layer)
    );
endmodule
